// ===== rtl/core/gbdi_pkg.sv =====
`timescale 1ns / 1ps

package gbdi_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int SCALE_W  = 16;
   localparam int OUT_W    = 32;
   localparam int ANGLE_W  = 48;
   localparam int BAND_W   = 18;

   // Request codes.
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_CALIB  = 2'd1;
   localparam logic [1:0] REQ_STOP   = 2'd2;

   // Reported mode codes.
   localparam logic [1:0] MODE_STOPPED = 2'd0;
   localparam logic [1:0] MODE_CALIB   = 2'd1;
   localparam logic [1:0] MODE_READY   = 2'd2;
   localparam logic [1:0] MODE_CAPTURE = 2'd3;

   // Running max and min start from these presets at each calibration.
   localparam logic signed [BAND_W-1:0] MAX_PRESET = -18'sd32700;
   localparam logic signed [BAND_W-1:0] MIN_PRESET = 18'sd32700;

   // Reporting divides by one million: a shift by 6, then a divide by 15625
   // done as a reciprocal estimate and a remainder correction.
   localparam logic [63:0] SAT_LIMIT = 64'd2147483648000000;
   localparam int          NUM_LSB   = 6;
   localparam int          NUM_W     = 45;
   localparam int          EST_LSB   = 20;
   localparam int          EST_W     = 31;
   localparam logic [32:0] RECIP     = 33'd4503599627;
   localparam logic [15:0] MICRO_ODD = 16'd15625;
   localparam int          REM_W     = 16;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 48'sh8000_0000_0000;

   typedef enum logic [3:0] {
      ST_STOPPED = 4'b0001,
      ST_CALIB   = 4'b0010,
      ST_READY   = 4'b0100,
      ST_CAPTURE = 4'b1000
   } run_state_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic       is_ready;
      logic       ready_event;
      logic       capture_event;
   } rsp_meta_type;

endpackage

// ===== rtl/core/gyro_bias_deadband_integrator_core.sv =====
`timescale 1ns / 1ps

// Gyro bias calibration and dead-band angle integrator.
//
// The req_ channel carries one command per transfer: a three-axis rate
// sample, a start-calibration command or a stop command. Every request
// transfer produces exactly one rsp_ transfer carrying the three integrated
// angles in degrees, the run mode after the request and two event flags.
// The csr_ channel writes the scale (millionths of a degree per LSB per
// sample); it is always ready and must only be written while the block is idle.
//
// Throughput is one request per clock while the receiver keeps up. On its way
// to rsp_valid a request lands in the input register at the transfer edge,
// then passes the state registers, four stages of the angle reporting
// pipeline (scale multiply, product sum, reciprocal estimate, remainder)
// and the response register.
// When the receiver holds rsp_ready low with a response waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is lost.
// Synchronous reset returns the block to the stopped mode with zero sums,
// zero bands and the scale at 700; no clearing pass is needed.
module gyro_bias_deadband_integrator_core #(
   parameter int CALIB_SAMPLES = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic signed [gbdi_pkg::SAMPLE_W-1:0] req_sample_x,
   input  logic signed [gbdi_pkg::SAMPLE_W-1:0] req_sample_y,
   input  logic signed [gbdi_pkg::SAMPLE_W-1:0] req_sample_z,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gbdi_pkg::OUT_W-1:0]    rsp_angle_x,
   output logic signed [gbdi_pkg::OUT_W-1:0]    rsp_angle_y,
   output logic signed [gbdi_pkg::OUT_W-1:0]    rsp_angle_z,
   output logic [1:0]                           rsp_mode,
   output logic                                 rsp_is_ready,
   output logic                                 rsp_ready_event,
   output logic                                 rsp_capture_event,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gbdi_pkg::SCALE_W-1:0]         csr_scale_micro_deg
);
   import gbdi_pkg::*;

   // The calibration sum must hold CALIB_SAMPLES full-scale samples.
   localparam int SUM_W = SAMPLE_W + $clog2(CALIB_SAMPLES);
   localparam int CNT_W = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
   localparam int LOG_C = $clog2(CALIB_SAMPLES);
   // Exact division by CALIB_SAMPLES of any magnitude below 2**SUM_W:
   // multiply by a rounded-up reciprocal, then shift.
   localparam int DIV_SHIFT = SUM_W + LOG_C;
   localparam int PROD_W    = 2 * SUM_W + 1;
   localparam logic [SUM_W:0] DIV_MAGIC = (SUM_W + 1)'(
      ((64'd1 << DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));
   localparam int META_STAGES = 5;

   // Handshake and pipeline advance: everything moves together unless a
   // response is waiting on a stalled receiver.
   logic en;
   logic process;

   logic                       item_valid_ff, item_valid_in;
   logic [1:0]                 item_type_ff;
   logic signed [SAMPLE_W-1:0] item_g_ff [3];

   logic [SCALE_W-1:0]         scale_ff;

   run_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [SUM_W-1:0]    zos_ff [3];
   logic signed [SUM_W-1:0]    zos_in [3];
   logic signed [BAND_W-1:0]   bh_ff [3];
   logic signed [BAND_W-1:0]   bh_in [3];
   logic signed [BAND_W-1:0]   bl_ff [3];
   logic signed [BAND_W-1:0]   bl_in [3];
   logic signed [ANGLE_W-1:0]  angle_ff [3];
   logic signed [ANGLE_W-1:0]  angle_in [3];
   logic                       fin_ff, fin_in;

   // Finalize path: zero = trunc(sum / CALIB_SAMPLES).
   logic                       fin_neg [3];
   logic [SUM_W-1:0]           fin_mag [3];
   logic [PROD_W-1:0]          fin_prod [3];
   logic [SAMPLE_W-1:0]        fin_q [3];
   logic [SUM_W:0]             fin_zero [3];

   // Capture path.
   logic signed [BAND_W-1:0]   gx [3];
   logic signed [BAND_W-1:0]   zero18 [3];
   logic signed [BAND_W-1:0]   dev [3];
   logic                       outside [3];

   logic                       ready_ev, capture_ev;
   rsp_meta_type               meta_in;
   rsp_meta_type               meta_ff [META_STAGES];

   logic signed [OUT_W-1:0]    angle_out [3];
   logic signed [OUT_W-1:0]    rsp_angle_ff [3];
   rsp_meta_type               rsp_meta_ff;

   function automatic logic signed [ANGLE_W-1:0] sat_add(
      input logic signed [ANGLE_W-1:0] a,
      input logic signed [BAND_W-1:0]  d
   );
      logic signed [ANGLE_W:0] s;
      s = (ANGLE_W + 1)'(a) + (ANGLE_W + 1)'(d);
      if (s[ANGLE_W] != s[ANGLE_W-1]) begin
         return s[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
      end
      return s[ANGLE_W-1:0];
   endfunction

   function automatic logic [1:0] mode_code(input run_state_type s);
      logic [1:0] m;
      case (s)
         ST_STOPPED: m = MODE_STOPPED;
         ST_CALIB:   m = MODE_CALIB;
         ST_READY:   m = MODE_READY;
         ST_CAPTURE: m = MODE_CAPTURE;
         default:    m = MODE_STOPPED;
      endcase
      return m;
   endfunction

   function automatic logic signed [BAND_W-1:0] zero18_from_fin(input logic [SUM_W:0] z);
      return BAND_W'(signed'(z[SAMPLE_W-1:0]));
   endfunction

   assign en            = !rsp_meta_ff.valid || rsp_ready;
   assign req_ready     = en;
   assign process       = en && item_valid_ff;
   assign item_valid_in = en ? req_valid : item_valid_ff;
   assign csr_ready     = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin_neg[i]  = zos_ff[i][SUM_W-1];
         fin_mag[i]  = fin_neg[i] ? SUM_W'(-zos_ff[i]) : SUM_W'(zos_ff[i]);
         fin_prod[i] = PROD_W'(fin_mag[i]) * PROD_W'(DIV_MAGIC);
         fin_q[i]    = fin_prod[i][DIV_SHIFT +: SAMPLE_W];
         fin_zero[i] = fin_neg[i] ? (SUM_W + 1)'(-(SUM_W + 1)'(fin_q[i]))
                                  : (SUM_W + 1)'(fin_q[i]);
         // After calibration the stored zero always fits a sample's width.
         zero18[i]   = BAND_W'(signed'(zos_ff[i][SAMPLE_W-1:0]));
         gx[i]       = BAND_W'(item_g_ff[i]);
         dev[i]      = gx[i] - zero18[i];
         outside[i]  = (dev[i] > bh_ff[i]) || (dev[i] < bl_ff[i]);
      end
   end

   // State update for the item in the input register. A pending finalize
   // only touches zeros and bands; the only item that can meet it in the
   // same cycle and also write them is a new calibrate, which wins.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      zos_in     = zos_ff;
      bh_in      = bh_ff;
      bl_in      = bl_ff;
      angle_in   = angle_ff;
      fin_in     = 1'b0;
      ready_ev   = 1'b0;
      capture_ev = 1'b0;

      if (fin_ff) begin
         for (int i = 0; i < 3; i++) begin
            zos_in[i] = fin_zero[i][SUM_W-1:0];
            bh_in[i]  = bh_ff[i] - zero18_from_fin(fin_zero[i]);
            bl_in[i]  = bl_ff[i] - zero18_from_fin(fin_zero[i]);
         end
      end

      if (process) begin
         case (item_type_ff)
            REQ_CALIB: begin
               state_in = ST_CALIB;
               count_in = '0;
               fin_in   = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  zos_in[i] = '0;
                  bh_in[i]  = MAX_PRESET;
                  bl_in[i]  = MIN_PRESET;
               end
            end
            REQ_STOP: begin
               state_in = ST_STOPPED;
            end
            REQ_SAMPLE: begin
               capture_ev = 1'b1;
               case (state_ff)
                  ST_CALIB: begin
                     for (int i = 0; i < 3; i++) begin
                        zos_in[i] = zos_ff[i] + SUM_W'(item_g_ff[i]);
                        if (gx[i] > bh_ff[i]) begin
                           bh_in[i] = gx[i];
                        end
                        if (gx[i] < bl_ff[i]) begin
                           bl_in[i] = gx[i];
                        end
                     end
                     if (count_ff == CNT_W'(CALIB_SAMPLES - 1)) begin
                        state_in = ST_READY;
                        fin_in   = 1'b1;
                        ready_ev = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ST_READY: begin
                     state_in = ST_CAPTURE;
                  end
                  ST_CAPTURE: begin
                     // x rate turns the y angle, y rate turns the x angle
                     // the other way, z stays on z.
                     if (outside[0]) begin
                        angle_in[1] = sat_add(angle_ff[1], dev[0]);
                     end
                     if (outside[1]) begin
                        angle_in[0] = sat_add(angle_ff[0], -dev[1]);
                     end
                     if (outside[2]) begin
                        angle_in[2] = sat_add(angle_ff[2], dev[2]);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      meta_in.valid         = process;
      meta_in.mode          = mode_code(state_in);
      meta_in.is_ready      = (state_in == ST_READY);
      meta_in.ready_event   = ready_ev;
      meta_in.capture_event = capture_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         scale_ff      <= 16'd700;
         state_ff      <= ST_STOPPED;
         count_ff      <= '0;
         fin_ff        <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            zos_ff[i]   <= '0;
            bh_ff[i]    <= '0;
            bl_ff[i]    <= '0;
            angle_ff[i] <= '0;
         end
         for (int k = 0; k < META_STAGES; k++) begin
            meta_ff[k] <= '0;
         end
         rsp_meta_ff <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (csr_valid && csr_ready) begin
            scale_ff <= csr_scale_micro_deg;
         end
         state_ff <= state_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         zos_ff   <= zos_in;
         bh_ff    <= bh_in;
         bl_ff    <= bl_in;
         angle_ff <= angle_in;
         if (en) begin
            meta_ff[0] <= meta_in;
            for (int k = 1; k < META_STAGES; k++) begin
               meta_ff[k] <= meta_ff[k-1];
            end
            rsp_meta_ff <= meta_ff[META_STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_type_ff <= req_type;
         item_g_ff[0] <= req_sample_x;
         item_g_ff[1] <= req_sample_y;
         item_g_ff[2] <= req_sample_z;
         rsp_angle_ff <= angle_out;
      end
   end

   // The reporting pipeline reads the registered angle sums in angle_ff, in step
   // with the mode and event flags travelling in meta_ff.
   for (genvar a = 0; a < 3; a++) begin : g_report
      gbdi_report u_report (
         .clock  (clock),
         .en     (en),
         .sum_in (angle_ff[a]),
         .scale  (scale_ff),
         .angle  (angle_out[a])
      );
   end

   assign rsp_valid         = rsp_meta_ff.valid;
   assign rsp_angle_x       = rsp_angle_ff[0];
   assign rsp_angle_y       = rsp_angle_ff[1];
   assign rsp_angle_z       = rsp_angle_ff[2];
   assign rsp_mode          = rsp_meta_ff.mode;
   assign rsp_is_ready      = rsp_meta_ff.is_ready;
   assign rsp_ready_event   = rsp_meta_ff.ready_event;
   assign rsp_capture_event = rsp_meta_ff.capture_event;

endmodule

// ===== rtl/core/gbdi_report.sv =====
`timescale 1ns / 1ps

// Converts one 48-bit angle sum to degrees: trunc(sum * scale / 1e6),
// saturated to 32 bits. Four register stages; the final correction is
// combinational and is registered by the caller.
module gbdi_report (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [gbdi_pkg::ANGLE_W-1:0]   sum_in,
   input  logic        [gbdi_pkg::SCALE_W-1:0]   scale,
   output logic signed [gbdi_pkg::OUT_W-1:0]     angle
);
   import gbdi_pkg::*;

   logic [ANGLE_W-1:0] mag;
   logic [31:0]        pp_in [3];
   logic [31:0]        pp_ff [3];
   logic               neg1_ff;

   logic [63:0]        prod_in;
   logic [63:0]        prod_ff;
   logic               neg2_ff;

   logic [EST_W-1:0]   est_num;
   logic [63:0]        est_prod;
   logic               sat3_in;
   logic               sat3_ff;
   logic               neg3_ff;
   logic [NUM_W-1:0]   num3_ff;
   logic [EST_W-1:0]   qe3_in;
   logic [EST_W-1:0]   qe3_ff;

   logic [REM_W-1:0]   rem4_in;
   logic [REM_W-1:0]   rem4_ff;
   logic [EST_W-1:0]   qe4_ff;
   logic               sat4_ff;
   logic               neg4_ff;

   logic [1:0]         corr;
   logic [OUT_W-1:0]   quot;

   // Stage 1: magnitude split into 16-bit pieces, each times the scale.
   assign mag = sum_in[ANGLE_W-1] ? ANGLE_W'(-sum_in) : ANGLE_W'(sum_in);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pp_in[k] = 32'(mag[16*k +: 16]) * 32'(scale);
      end
   end

   // Stage 2: partial products summed to the full product magnitude.
   assign prod_in = 64'(pp_ff[0]) + (64'(pp_ff[1]) << 16) + (64'(pp_ff[2]) << 32);

   // Stage 3: overflow check and a quotient estimate that is low by at most 3.
   assign sat3_in  = prod_ff >= SAT_LIMIT;
   assign est_num  = prod_ff[EST_LSB +: EST_W];
   assign est_prod = 64'(est_num) * 64'(RECIP);
   assign qe3_in   = est_prod[32 +: EST_W];

   // Stage 4: remainder of the estimate.
   assign rem4_in = REM_W'(num3_ff - NUM_W'(qe3_ff) * NUM_W'(MICRO_ODD));

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         neg1_ff <= sum_in[ANGLE_W-1];
         prod_ff <= prod_in;
         neg2_ff <= neg1_ff;
         sat3_ff <= sat3_in;
         neg3_ff <= neg2_ff;
         num3_ff <= prod_ff[NUM_LSB +: NUM_W];
         qe3_ff  <= qe3_in;
         rem4_ff <= rem4_in;
         qe4_ff  <= qe3_ff;
         sat4_ff <= sat3_ff;
         neg4_ff <= neg3_ff;
      end
   end

   always_comb begin
      corr = 2'd0;
      if (rem4_ff >= 3 * MICRO_ODD) begin
         corr = 2'd3;
      end else if (rem4_ff >= 2 * MICRO_ODD) begin
         corr = 2'd2;
      end else if (rem4_ff >= MICRO_ODD) begin
         corr = 2'd1;
      end
      quot = OUT_W'(qe4_ff) + OUT_W'(corr);
      if (sat4_ff) begin
         angle = neg4_ff ? OUT_MIN : OUT_MAX;
      end else begin
         angle = neg4_ff ? OUT_W'(-quot) : OUT_W'(quot);
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import gbdi_pkg::*;

   localparam int CALIB_SAMPLES = 100;
   // No new random sequence starts once this many commands, unused codes apart, have been accepted.
   localparam int ITEMS_TARGET = 1050;
   // Margin waited after every answer is back, before the summary is printed.
   localparam int DRAIN_CYCLES = 20;
   // The longest quiet stretch in a correct run is a sender gap plus the
   // pipeline latency plus a receiver stall.
   localparam int WATCHDOG_LIMIT = 2000;
   // The request code the block leaves unused; it must still be answered.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // One response as the block should present it.
   typedef struct packed {
      logic signed [gbdi_pkg::OUT_W-1:0] angle_x;
      logic signed [gbdi_pkg::OUT_W-1:0] angle_y;
      logic signed [gbdi_pkg::OUT_W-1:0] angle_z;
      logic [1:0]                        mode;
      logic                              is_ready;
      logic                              ready_event;
      logic                              capture_event;
   } angle_report_type;

   class angle_tracker;
      logic [gbdi_pkg::SCALE_W-1:0]        scale;
      logic [1:0]                          run_mode;
      int unsigned                         calib_count;
      // Running sum while calibrating, the zero offset afterwards.
      logic signed [23:0]                  axis_bias[3];
      logic signed [gbdi_pkg::BAND_W-1:0]  band_hi[3];
      logic signed [gbdi_pkg::BAND_W-1:0]  band_lo[3];
      logic signed [gbdi_pkg::ANGLE_W-1:0] angle_acc[3];

      angle_report_type pending_reports[$];
      int unsigned      mismatches;
      int unsigned      reports_checked;
      int unsigned      calibrations_done;
      int unsigned      band_hits;

      function new();
         scale = 16'd700;
         run_mode = gbdi_pkg::MODE_STOPPED;
         calib_count = 0;
         mismatches = 0;
         reports_checked = 0;
         calibrations_done = 0;
         band_hits = 0;
         for (int i = 0; i < 3; i++) begin
            axis_bias[i] = '0;
            band_hi[i] = '0;
            band_lo[i] = '0;
            angle_acc[i] = '0;
         end
      endfunction

      function logic signed [gbdi_pkg::ANGLE_W-1:0] add_clipped(
            logic signed [gbdi_pkg::ANGLE_W-1:0] acc, logic signed [24:0] delta);
         logic signed [gbdi_pkg::ANGLE_W:0] total;
         total = acc + delta;
         if (total > gbdi_pkg::ANGLE_MAX) return gbdi_pkg::ANGLE_MAX;
         if (total < gbdi_pkg::ANGLE_MIN) return gbdi_pkg::ANGLE_MIN;
         return total[gbdi_pkg::ANGLE_W-1:0];
      endfunction

      // Degrees = trunc(acc * scale / 1e6), clipped to 32 bits.
      function logic signed [gbdi_pkg::OUT_W-1:0] degrees(
            logic signed [gbdi_pkg::ANGLE_W-1:0] acc);
         longint product;
         longint quotient;
         product = longint'(acc) * longint'(scale);
         quotient = product / 1000000;
         if (quotient > longint'(gbdi_pkg::OUT_MAX)) return gbdi_pkg::OUT_MAX;
         if (quotient < longint'(gbdi_pkg::OUT_MIN)) return gbdi_pkg::OUT_MIN;
         return quotient[gbdi_pkg::OUT_W-1:0];
      endfunction

      function void note_request(logic [1:0] kind, logic signed [15:0] gx,
                                 logic signed [15:0] gy, logic signed [15:0] gz);
         logic signed [15:0] g[3];
         logic signed [24:0] dev;
         angle_report_type   due;
         logic               ready_ev;
         logic               capture_ev;
         g[0] = gx;
         g[1] = gy;
         g[2] = gz;
         ready_ev = 1'b0;
         capture_ev = 1'b0;
         case (kind)
            gbdi_pkg::REQ_CALIB: begin
               run_mode = gbdi_pkg::MODE_CALIB;
               calib_count = 0;
               for (int i = 0; i < 3; i++) begin
                  axis_bias[i] = '0;
                  band_hi[i] = gbdi_pkg::MAX_PRESET;
                  band_lo[i] = gbdi_pkg::MIN_PRESET;
               end
            end
            gbdi_pkg::REQ_STOP: begin
               run_mode = gbdi_pkg::MODE_STOPPED;
            end
            gbdi_pkg::REQ_SAMPLE: begin
               capture_ev = 1'b1;
               if (run_mode == gbdi_pkg::MODE_CALIB) begin
                  for (int i = 0; i < 3; i++) begin
                     axis_bias[i] += g[i];
                     if (g[i] > band_hi[i]) band_hi[i] = g[i];
                     if (g[i] < band_lo[i]) band_lo[i] = g[i];
                  end
                  calib_count++;
                  if (calib_count >= CALIB_SAMPLES) begin
                     for (int i = 0; i < 3; i++) begin
                        axis_bias[i] = axis_bias[i] / CALIB_SAMPLES;
                        band_hi[i] = band_hi[i] - axis_bias[i];
                        band_lo[i] = band_lo[i] - axis_bias[i];
                     end
                     run_mode = gbdi_pkg::MODE_READY;
                     ready_ev = 1'b1;
                     calibrations_done++;
                  end
               end else if (run_mode == gbdi_pkg::MODE_READY) begin
                  run_mode = gbdi_pkg::MODE_CAPTURE;
               end else if (run_mode == gbdi_pkg::MODE_CAPTURE) begin
                  // Axes cross over: x rate turns the y angle, y rate turns x backwards.
                  dev = g[0] - axis_bias[0];
                  if (dev > band_hi[0] || dev < band_lo[0]) begin
                     angle_acc[1] = add_clipped(angle_acc[1], dev);
                     band_hits++;
                  end
                  dev = g[1] - axis_bias[1];
                  if (dev > band_hi[1] || dev < band_lo[1]) begin
                     angle_acc[0] = add_clipped(angle_acc[0], -dev);
                     band_hits++;
                  end
                  dev = g[2] - axis_bias[2];
                  if (dev > band_hi[2] || dev < band_lo[2]) begin
                     angle_acc[2] = add_clipped(angle_acc[2], dev);
                     band_hits++;
                  end
               end
            end
            default: begin
            end
         endcase
         due.angle_x = degrees(angle_acc[0]);
         due.angle_y = degrees(angle_acc[1]);
         due.angle_z = degrees(angle_acc[2]);
         due.mode = run_mode;
         due.is_ready = (run_mode == gbdi_pkg::MODE_READY);
         due.ready_event = ready_ev;
         due.capture_event = capture_ev;
         pending_reports.push_back(due);
      endfunction

      function void compare_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] seen);
         if (want !== seen) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, seen);
         end
      endfunction

      function void check_report(angle_report_type got);
         angle_report_type due;
         if (pending_reports.size() == 0) begin
            mismatches++;
            $error("response transfer with no request outstanding");
            return;
         end
         due = pending_reports.pop_front();
         reports_checked++;
         compare_field("angle_x", due.angle_x, got.angle_x);
         compare_field("angle_y", due.angle_y, got.angle_y);
         compare_field("angle_z", due.angle_z, got.angle_z);
         compare_field("mode", due.mode, got.mode);
         compare_field("is_ready", due.is_ready, got.is_ready);
         compare_field("ready_event", due.ready_event, got.ready_event);
         compare_field("capture_event", due.capture_event, got.capture_event);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_type = REQ_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_x = '0;
   logic signed [SAMPLE_W-1:0] req_sample_y = '0;
   logic signed [SAMPLE_W-1:0] req_sample_z = '0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   logic signed [OUT_W-1:0]    rsp_angle_x;
   logic signed [OUT_W-1:0]    rsp_angle_y;
   logic signed [OUT_W-1:0]    rsp_angle_z;
   logic [1:0]                 rsp_mode;
   logic                       rsp_is_ready;
   logic                       rsp_ready_event;
   logic                       rsp_capture_event;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [SCALE_W-1:0]         csr_scale_micro_deg = '0;

   angle_tracker tracker = new();

   // When set, the matching side runs back to back with no idle cycles.
   bit send_fast = 1'b0;
   bit recv_fast = 1'b0;
   // Idle cycles owed before the next request, and whether valid is up.
   int pending_gap = 0;
   bit req_offered = 1'b0;
   int items_sent = 0;
   int scale_phases = 1;
   int stall_left = 0;

   gyro_bias_deadband_integrator_core #(
      .CALIB_SAMPLES(CALIB_SAMPLES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_sample_x(req_sample_x),
      .req_sample_y(req_sample_y),
      .req_sample_z(req_sample_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_angle_x(rsp_angle_x),
      .rsp_angle_y(rsp_angle_y),
      .rsp_angle_z(rsp_angle_z),
      .rsp_mode(rsp_mode),
      .rsp_is_ready(rsp_is_ready),
      .rsp_ready_event(rsp_ready_event),
      .rsp_capture_event(rsp_capture_event),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_scale_micro_deg(csr_scale_micro_deg)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int idle_draw(input bit fast);
      return fast ? 0 : int'($urandom_range(0, 15));
   endfunction

   function automatic logic signed [15:0] random_rate();
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic signed [15:0] clamp_rate(input int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // A capture sample for one axis. Half land near the dead band, some sit
   // exactly on or just past its edges (the compare is strict), the rest
   // span the whole input range.
   function automatic logic signed [15:0] capture_rate(input int axis);
      int bias;
      int hi;
      int lo;
      int v;
      bias = tracker.axis_bias[axis];
      hi = tracker.band_hi[axis];
      lo = tracker.band_lo[axis];
      case ($urandom_range(0, 9))
         0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
         3, 4: begin
            case ($urandom_range(0, 3))
               0: v = bias + hi;
               1: v = bias + hi + 1;
               2: v = bias + lo;
               default: v = bias + lo - 1;
            endcase
         end
         default: v = bias + lo - 4 + int'($urandom_range(0, hi - lo + 8));
      endcase
      return clamp_rate(v);
   endfunction

   // Offers one command and waits for its transfer. The gap before the
   // following command is drawn here, so valid drops right at the transfer
   // edge when a gap follows and stays up otherwise.
   task automatic send_request(input logic [1:0] kind, input logic signed [15:0] gx,
                               input logic signed [15:0] gy, input logic signed [15:0] gz);
      repeat (pending_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample_x <= gx;
      req_sample_y <= gy;
      req_sample_z <= gz;
      req_offered = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(kind, gx, gy, gz);
      if (kind != REQ_UNUSED) items_sent++;
      pending_gap = idle_draw(send_fast);
      if (pending_gap > 0) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
   endtask

   // Withdraws the request channel and waits until every answer is back.
   task automatic quiesce();
      if (req_offered) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
      pending_gap = 0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
   endtask

   // The scale is changed only with the pipeline empty.
   task automatic write_scale(input logic [SCALE_W-1:0] value);
      quiesce();
      csr_valid <= 1'b1;
      csr_scale_micro_deg <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.scale = value;
      scale_phases++;
   endtask

   // A full calibration. The style picks the sample content: a quiet bias
   // with a little noise, all at the negative limit, all at the positive
   // limit (both keep a preset extreme), or noise over the whole range.
   // Now and then the run is broken off by a stop or a restart, and a few
   // unused-code commands are mixed in.
   task automatic run_calibration(input int style);
      int base[3];
      int amp;
      int count;
      int broken_at;
      int v;
      logic signed [15:0] g[3];
      for (int i = 0; i < 3; i++) base[i] = int'($urandom_range(0, 6000)) - 3000;
      amp = $urandom_range(1, 60);
      broken_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, CALIB_SAMPLES - 1)) : -1;
      send_request(REQ_CALIB, random_rate(), random_rate(), random_rate());
      count = 0;
      while (count < CALIB_SAMPLES) begin
         if (count == broken_at) begin
            broken_at = -1;
            if ($urandom_range(0, 1) == 0) begin
               send_request(REQ_STOP, random_rate(), random_rate(), random_rate());
               send_request(REQ_SAMPLE, random_rate(), random_rate(), random_rate());
            end
            send_request(REQ_CALIB, random_rate(), random_rate(), random_rate());
            count = 0;
         end else begin
            if ($urandom_range(0, 29) == 0)
               send_request(REQ_UNUSED, random_rate(), random_rate(), random_rate());
            for (int i = 0; i < 3; i++) begin
               case (style)
                  0: v = base[i] + int'($urandom_range(0, 2 * amp)) - amp;
                  1: v = -32768;
                  2: v = 32767;
                  default: v = int'($urandom_range(0, 65535)) - 32768;
               endcase
               g[i] = clamp_rate(v);
            end
            send_request(REQ_SAMPLE, g[0], g[1], g[2]);
            count++;
         end
      end
   endtask

   // Capture samples with occasional noise commands; a stop ends it early.
   task automatic run_capture(input int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 59);
         if (r == 0) begin
            send_request(REQ_UNUSED, random_rate(), random_rate(), random_rate());
         end else if (r == 1) begin
            send_request(REQ_STOP, random_rate(), random_rate(), random_rate());
            repeat ($urandom_range(1, 3))
               send_request(REQ_SAMPLE, random_rate(), random_rate(), random_rate());
            return;
         end else begin
            send_request(REQ_SAMPLE, capture_rate(0), capture_rate(1), capture_rate(2));
         end
      end
   endtask

   // Response side: check every transfer, then draw a stall before the next.
   always @(posedge clock) begin
      angle_report_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.angle_x = rsp_angle_x;
            got.angle_y = rsp_angle_y;
            got.angle_z = rsp_angle_z;
            got.mode = rsp_mode;
            got.is_ready = rsp_is_ready;
            got.ready_event = rsp_ready_event;
            got.capture_event = rsp_capture_event;
            tracker.check_report(got);
            stall_left = idle_draw(recv_fast);
            if (stall_left > 0) rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no channel has moved a transfer for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int seq;
      int r;
      logic [SCALE_W-1:0] next_scale;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset scale: samples while stopped at the field
      // extremes, the unused code, stop while stopped, then a calibration that
      // is restarted and finally stopped before it can complete.
      send_request(REQ_SAMPLE, 16'sh7FFF, -16'sh8000, 16'sh0000);
      send_request(REQ_SAMPLE, -16'sh8000, 16'sh7FFF, -16'sh0001);
      send_request(REQ_UNUSED, 16'sh5555, -16'sh5556, 16'sh7FFF);
      send_request(REQ_STOP, -16'sh8000, -16'sh8000, -16'sh8000);
      send_request(REQ_CALIB, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_request(REQ_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_request(REQ_SAMPLE, -16'sh8000, -16'sh8000, -16'sh8000);
      send_request(REQ_SAMPLE, 16'sh0000, -16'sh0001, 16'sh0001);
      send_request(REQ_UNUSED, 16'sh0000, 16'sh0000, 16'sh0000);
      send_request(REQ_CALIB, -16'sh8000, 16'sh0000, 16'sh7FFF);
      send_request(REQ_SAMPLE, 16'sh1234, -16'sh1234, 16'sh0FF0);
      send_request(REQ_STOP, 16'sh0000, 16'sh0000, 16'sh0000);
      send_request(REQ_SAMPLE, -16'sh8000, 16'sh7FFF, -16'sh8000);
      send_request(REQ_STOP, 16'sh7FFF, -16'sh8000, 16'sh0000);

      // Random part: whole calibrate-and-capture sequences, each phase at a
      // scale of its own. The first phases take the scale extremes and the
      // first calibrations take each sample style once.
      seq = 0;
      while (items_sent < ITEMS_TARGET) begin
         if (seq > 0) begin
            case (seq)
               1: next_scale = 16'd65535;
               2: next_scale = 16'd1;
               3: next_scale = 16'd0;
               4: next_scale = 16'd700;
               default: next_scale = SCALE_W'($urandom_range(1, 65535));
            endcase
            write_scale(next_scale);
         end
         send_fast = ($urandom_range(0, 3) == 0);
         recv_fast = ($urandom_range(0, 3) == 0);
         run_calibration((seq < 4) ? seq : int'($urandom_range(0, 3)));

         // Disturb the ready mode now and then before capture begins.
         r = $urandom_range(0, 7);
         if (r == 0) begin
            send_request(REQ_UNUSED, random_rate(), random_rate(), random_rate());
         end else if (r == 1) begin
            send_request(REQ_STOP, random_rate(), random_rate(), random_rate());
            send_request(REQ_SAMPLE, random_rate(), random_rate(), random_rate());
            run_calibration(0);
         end else if (r == 2) begin
            run_calibration(int'($urandom_range(0, 3)));
         end

         run_capture($urandom_range(30, 150));
         // Either stop, or let the next calibration start straight from capture.
         if ($urandom_range(0, 1) == 0) begin
            send_request(REQ_STOP, random_rate(), random_rate(), random_rate());
            send_request(REQ_SAMPLE, random_rate(), random_rate(), random_rate());
         end
         seq++;
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d commands and %0d checked responses, %0d calibrations done.",
               items_sent, tracker.reports_checked, tracker.calibrations_done);
      $display("Dead band was crossed %0d times over %0d scale settings.",
               tracker.band_hits, scale_phases);
      if (tracker.mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
